// ===== src/zste_pkg.sv =====
// Package for the zoomed sprite tile expander.
// Widths, size and register codes, state type, offset tables and the
// code unit request/result structs. No dependencies.
package zste_pkg;

    // Code width actually decoded; the code port stays 16 bits.
    localparam int CODE_WIDTH     = 16;
    localparam int CODE_W         = 16;
    localparam int CODE_USED      = (CODE_WIDTH < CODE_W) ? CODE_WIDTH : CODE_W;
    localparam logic [CODE_W-1:0] CODE_ALL_MASK =
        CODE_W'((33'(1) << CODE_USED) - 33'(1));

    localparam int ZOOM_W      = 10;
    localparam int SCALE_W     = 24;        // 2^23 / 1 needs 24 bits
    localparam int DIVIDEND_MSB = 23;       // dividend is 1 << 23
    localparam int ACC_W       = 26;        // scale * 4 + rounding half
    localparam int ROUND_SHIFT = 13;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);
    localparam int POS_W       = 14;
    localparam int SIZE_W      = 13;
    localparam int SHIFT_W     = 9;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_SHIFT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_SHIFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP       = 3'd4;

    // Size field codes (attribute bits 6..4)
    localparam logic [2:0] SIZE_2X2 = 3'd0;
    localparam logic [2:0] SIZE_1X2 = 3'd1;
    localparam logic [2:0] SIZE_2X1 = 3'd2;
    localparam logic [2:0] SIZE_1X1 = 3'd3;
    localparam logic [2:0] SIZE_4X4 = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PLACE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [CODE_W-1:0] code;      // masked and aligned base code
        logic [CODE_W-1:0] bank_mask;
        logic [CODE_W-1:0] bank;
        logic [1:0]        w_m1;
        logic [1:0]        h_m1;
        logic              mirror_x;
        logic              mirror_y;
        logic [1:0]        tx;
        logic [1:0]        ty;
    } t_code_req;

    typedef struct packed {
        logic              ok;        // offset code stays inside its bank
        logic [CODE_W-1:0] code;
    } t_code_res;

    function automatic logic [3:0] col_offset(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0:    v = 4'd0;
            2'd1:    v = 4'd1;
            2'd2:    v = 4'd4;
            default: v = 4'd5;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] row_offset(input logic [1:0] idx);
        logic [3:0] v;
        case (idx)
            2'd0:    v = 4'd0;
            2'd1:    v = 4'd2;
            2'd2:    v = 4'd8;
            default: v = 4'd10;
        endcase
        return v;
    endfunction

endpackage

// ===== src/zste_div.sv =====
// Serial restoring divider: quotient of 2^23 by a ten-bit zoom value,
// one quotient bit per cycle. Depends on zste_pkg.
module zste_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [zste_pkg::ZOOM_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [zste_pkg::SCALE_W-1:0]   o_quotient
);

    localparam int CNT_W = $clog2(zste_pkg::DIVIDEND_MSB + 1);

    logic                          r_busy;
    logic [CNT_W-1:0]              r_cnt;
    logic [zste_pkg::ZOOM_W-1:0]   r_div;
    logic [zste_pkg::ZOOM_W-1:0]   r_rem;
    logic [zste_pkg::SCALE_W-1:0]  r_quo;
    logic                          r_done;

    logic [zste_pkg::ZOOM_W:0]     trial;
    logic [zste_pkg::ZOOM_W:0]     diff;
    logic                          ge;

    // dividend has a single one at its top bit
    assign trial = {r_rem, (r_cnt == CNT_W'(zste_pkg::DIVIDEND_MSB))};
    assign ge    = trial >= {1'b0, r_div};
    assign diff  = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(zste_pkg::DIVIDEND_MSB);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[zste_pkg::ZOOM_W-1:0] : trial[zste_pkg::ZOOM_W-1:0];
            r_quo <= {r_quo[zste_pkg::SCALE_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/zste_code.sv =====
// Tile code unit: adds the column and row offsets for one tile, checks
// the bank bits and adds the bank back. Depends on zste_pkg.
module zste_code (
    input  zste_pkg::t_code_req i_req,
    output zste_pkg::t_code_res o_res
);

    logic [1:0]                  col_idx;
    logic [1:0]                  row_idx;
    logic [zste_pkg::CODE_W-1:0] sum;

    always_comb begin
        // mirrored tiles walk the offset tables backwards
        col_idx = i_req.mirror_x ? (i_req.w_m1 - i_req.tx) : i_req.tx;
        row_idx = i_req.mirror_y ? (i_req.h_m1 - i_req.ty) : i_req.ty;
        sum = i_req.code
            + zste_pkg::CODE_W'(zste_pkg::col_offset(col_idx))
            + zste_pkg::CODE_W'(zste_pkg::row_offset(row_idx));
        o_res.ok   = (sum & i_req.bank_mask) == '0;
        o_res.code = sum + i_req.bank;
    end

endmodule

// ===== src/zoomed_sprite_tile_expander.sv =====
// Top level of the zoomed sprite tile expander: configuration registers,
// sequencer, placement datapath and output register.
// Depends on zste_pkg, zste_div and zste_code.
//
//  channel  | valid       | stall       | payload
//  ---------+-------------+-------------+------------------------------------------
//  config   | i_cfg_wr_en | -           | i_cfg_index, i_cfg_wdata
//  input    | i_in_valid  | o_in_stall  | i_y_byte .. i_zoom_low_byte
//  output   | o_out_valid | i_out_stall | o_out_code .. o_last_tile
//
// An item runs through the serial divider (its quotient bits and a done
// step; the bank check of all tiles runs alongside), one placement state,
// then emits each tile up to the last drawn one plus a wrap copy of each
// drawn tile when wrap is on; the next item is accepted once back in idle.
// A zero zoom item finishes at acceptance.
// Output stalls hold the sequencer only when a command is ready to load.
// Reset is synchronous; it restores the configuration registers and the sequencer state and empties the output.
module zoomed_sprite_tile_expander (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_wr_en,
    input  logic [zste_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [zste_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [7:0]                             i_y_byte,
    input  logic [15:0]                            i_tile_code,
    input  logic [7:0]                             i_tile_color,
    input  logic [7:0]                             i_x_low_byte,
    input  logic [7:0]                             i_attribute_byte,
    input  logic [7:0]                             i_zoom_low_byte,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic [15:0]                            o_out_code,
    output logic signed [zste_pkg::POS_W-1:0]      o_draw_x,
    output logic signed [zste_pkg::POS_W-1:0]      o_draw_y,
    output logic [zste_pkg::SIZE_W-1:0]            o_draw_width,
    output logic [zste_pkg::SIZE_W-1:0]            o_draw_height,
    output logic                                   o_mirror_x,
    output logic                                   o_mirror_y,
    output logic [7:0]                             o_palette_color,
    output logic                                   o_last_tile
);

    localparam int CW = zste_pkg::CODE_W;
    localparam int PW = zste_pkg::POS_W;
    localparam int SW = zste_pkg::SIZE_W;
    localparam int AW = zste_pkg::ACC_W;
    localparam int QW = zste_pkg::SCALE_W;
    localparam logic [PW-1:0] LINE_WRAP = PW'(256);

    // configuration
    logic [CW-1:0]                        r_code_limit;
    logic [zste_pkg::SHIFT_W-1:0]         r_x_shift;
    logic [zste_pkg::SHIFT_W-1:0]         r_y_shift;
    logic                                 r_flip;
    logic                                 r_wrap;

    zste_pkg::t_state r_state, n_state;

    // per item
    logic [CW-1:0]  r_code, r_bank_mask, r_bank;
    logic [1:0]     r_w_m1, r_h_m1;
    logic           r_mx, r_my;
    logic [7:0]     r_color;
    logic [PW-1:0]  r_ox, r_oy;        // sprite origin, later base minus shift
    logic [3:0]     r_scan_idx;
    logic           r_scan_done;
    logic [3:0]     r_last_idx;
    logic           r_any;
    logic [1:0]     r_tx, r_ty;
    logic           r_copy;
    logic [AW-1:0]  r_acc_x, r_acc_y;  // scale * n + rounding half

    // output register
    logic           r_out_valid;
    logic [CW-1:0]  r_out_code;
    logic [PW-1:0]  r_out_x, r_out_y;
    logic [SW-1:0]  r_out_w, r_out_h;
    logic           r_out_mx, r_out_my, r_out_last;
    logic [7:0]     r_out_color;

    // control
    logic           in_acc, start_div, ld_out, advance, set_copy, out_free;
    logic           div_done, tile_last, cmd_last, scan_hit;
    logic [QW-1:0]  scale;

    // accept-time decode
    logic [zste_pkg::ZOOM_W-1:0] zval;
    logic [CW-1:0]  in_code, in_bank_mask, acc_code;
    logic [1:0]     acc_w_m1, acc_h_m1;

    // arithmetic
    logic [AW-1:0]  span_w, span_h, sum_x, sum_y;
    logic [SW-1:0]  ext_w, ext_h;
    logic [SW-1:0]  rnd_x0, rnd_x1, rnd_y0, rnd_y1;
    logic [PW-1:0]  base_x, base_y, pos_x, pos_y;

    zste_pkg::t_code_req code_req;
    zste_pkg::t_code_res code_res;

    zste_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start_div),
        .i_divisor  (zval),
        .o_done     (div_done),
        .o_quotient (scale)
    );

    zste_code u_code (
        .i_req (code_req),
        .o_res (code_res)
    );

    assign o_in_stall = (r_state != zste_pkg::ST_IDLE);
    assign in_acc     = i_in_valid && (r_state == zste_pkg::ST_IDLE);
    assign zval       = {i_attribute_byte[1:0], i_zoom_low_byte};
    assign start_div  = in_acc && (zval != '0);
    assign out_free   = !r_out_valid || !i_out_stall;

    // size decode and code alignment
    always_comb begin
        in_code      = i_tile_code & zste_pkg::CODE_ALL_MASK;
        in_bank_mask = ~r_code_limit & zste_pkg::CODE_ALL_MASK;
        acc_code     = in_code & r_code_limit;
        acc_w_m1     = 2'd0;
        acc_h_m1     = 2'd0;
        case (i_attribute_byte[6:4])
            zste_pkg::SIZE_2X1: begin
                acc_w_m1 = 2'd1;
                acc_code = acc_code & ~CW'(1);
            end
            zste_pkg::SIZE_1X2: begin
                acc_h_m1 = 2'd1;
                acc_code = acc_code & ~CW'(2);
            end
            zste_pkg::SIZE_2X2: begin
                acc_w_m1 = 2'd1;
                acc_h_m1 = 2'd1;
                acc_code = acc_code & ~CW'(3);
            end
            zste_pkg::SIZE_4X4: begin
                acc_w_m1 = 2'd3;
                acc_h_m1 = 2'd3;
                acc_code = acc_code & ~CW'(3);
            end
            default: ;  // 1x1 and the unused codes
        endcase
    end

    // code unit is shared by the bank scan and the emit pass
    always_comb begin
        code_req.code      = r_code;
        code_req.bank_mask = r_bank_mask;
        code_req.bank      = r_bank;
        code_req.w_m1      = r_w_m1;
        code_req.h_m1      = r_h_m1;
        code_req.mirror_x  = r_mx;
        code_req.mirror_y  = r_my;
        if (r_state == zste_pkg::ST_EMIT) begin
            code_req.tx = r_tx;
            code_req.ty = r_ty;
        end else begin
            code_req.tx = r_scan_idx[1:0];
            code_req.ty = r_scan_idx[3:2];
        end
    end

    assign scan_hit = !r_scan_done && (r_scan_idx[1:0] <= r_w_m1)
                   && (r_scan_idx[3:2] <= r_h_m1) && code_res.ok;

    // flip-screen extent: round(scale * w), w is 1, 2 or 4
    always_comb begin
        case (r_w_m1)
            2'd0:    span_w = AW'(scale);
            2'd1:    span_w = AW'(scale) << 1;
            default: span_w = AW'(scale) << 2;
        endcase
        case (r_h_m1)
            2'd0:    span_h = AW'(scale);
            2'd1:    span_h = AW'(scale) << 1;
            default: span_h = AW'(scale) << 2;
        endcase
    end

    always_comb begin
        ext_w = SW'((span_w + zste_pkg::ROUND_HALF) >> zste_pkg::ROUND_SHIFT);
        ext_h = SW'((span_h + zste_pkg::ROUND_HALF) >> zste_pkg::ROUND_SHIFT);
        base_x = r_flip ? (LINE_WRAP - r_ox - PW'(ext_w)) : r_ox;
        base_y = r_flip ? (LINE_WRAP - r_oy - PW'(ext_h)) : r_oy;
    end

    // tile placement from the running accumulators
    always_comb begin
        sum_x  = r_acc_x + AW'(scale);
        sum_y  = r_acc_y + AW'(scale);
        rnd_x0 = SW'(r_acc_x >> zste_pkg::ROUND_SHIFT);
        rnd_x1 = SW'(sum_x >> zste_pkg::ROUND_SHIFT);
        rnd_y0 = SW'(r_acc_y >> zste_pkg::ROUND_SHIFT);
        rnd_y1 = SW'(sum_y >> zste_pkg::ROUND_SHIFT);
        pos_x  = r_ox + PW'(rnd_x0);
        pos_y  = r_oy + PW'(rnd_y0) - (r_copy ? LINE_WRAP : '0);
    end

    assign tile_last = ({r_ty, r_tx} == r_last_idx);
    assign cmd_last  = tile_last && (!r_wrap || r_copy);

    // sequencer
    always_comb begin
        n_state  = r_state;
        ld_out   = 1'b0;
        advance  = 1'b0;
        set_copy = 1'b0;
        case (r_state)
            zste_pkg::ST_IDLE: begin
                if (start_div) begin
                    n_state = zste_pkg::ST_DIV;
                end
            end
            zste_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = r_any ? zste_pkg::ST_PLACE : zste_pkg::ST_IDLE;
                end
            end
            zste_pkg::ST_PLACE: begin
                n_state = zste_pkg::ST_EMIT;
            end
            zste_pkg::ST_EMIT: begin
                if (!code_res.ok) begin
                    advance = 1'b1;
                end else if (out_free) begin
                    ld_out = 1'b1;
                    if (r_wrap && !r_copy) begin
                        set_copy = 1'b1;
                    end else begin
                        advance = 1'b1;
                    end
                    if (cmd_last) begin
                        n_state = zste_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = zste_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= zste_pkg::ST_IDLE;
            r_code_limit <= CW'(16'hFFFF);
            r_x_shift    <= '0;
            r_y_shift    <= '0;
            r_flip       <= 1'b0;
            r_wrap       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    zste_pkg::REG_CODE_LIMIT: r_code_limit <= CW'(i_cfg_wdata);
                    zste_pkg::REG_X_SHIFT:    r_x_shift <= i_cfg_wdata[zste_pkg::SHIFT_W-1:0];
                    zste_pkg::REG_Y_SHIFT:    r_y_shift <= i_cfg_wdata[zste_pkg::SHIFT_W-1:0];
                    zste_pkg::REG_FLIP:       r_flip <= i_cfg_wdata[0];
                    zste_pkg::REG_WRAP:       r_wrap <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code      <= acc_code;
            r_bank_mask <= in_bank_mask;
            r_bank      <= in_code & in_bank_mask;
            r_w_m1      <= acc_w_m1;
            r_h_m1      <= acc_h_m1;
            r_mx        <= i_attribute_byte[2] ^ r_flip;
            r_my        <= i_attribute_byte[3] ^ r_flip;
            r_color     <= i_tile_color;
            r_ox        <= PW'($signed({i_attribute_byte[7], i_x_low_byte}));
            r_oy        <= LINE_WRAP - PW'(i_y_byte);
            r_scan_idx  <= '0;
            r_scan_done <= 1'b0;
            r_any       <= 1'b0;
        end
        if (r_state == zste_pkg::ST_DIV && !r_scan_done) begin
            if (scan_hit) begin
                r_last_idx <= r_scan_idx;
                r_any      <= 1'b1;
            end
            r_scan_idx <= r_scan_idx + 4'd1;
            if (r_scan_idx == 4'hF) begin
                r_scan_done <= 1'b1;
            end
        end
        if (r_state == zste_pkg::ST_PLACE) begin
            r_ox    <= base_x - PW'($signed(r_x_shift));
            r_oy    <= base_y - PW'($signed(r_y_shift));
            r_acc_x <= zste_pkg::ROUND_HALF;
            r_acc_y <= zste_pkg::ROUND_HALF;
            r_tx    <= '0;
            r_ty    <= '0;
            r_copy  <= 1'b0;
        end
        if (set_copy) begin
            r_copy <= 1'b1;
        end
        if (advance) begin
            r_copy <= 1'b0;
            if (r_tx == r_w_m1) begin
                r_tx    <= '0;
                r_ty    <= r_ty + 2'd1;
                r_acc_x <= zste_pkg::ROUND_HALF;
                r_acc_y <= sum_y;
            end else begin
                r_tx    <= r_tx + 2'd1;
                r_acc_x <= sum_x;
            end
        end
        if (ld_out) begin
            r_out_code  <= code_res.code;
            r_out_x     <= pos_x;
            r_out_y     <= pos_y;
            r_out_w     <= rnd_x1 - rnd_x0;
            r_out_h     <= rnd_y1 - rnd_y0;
            r_out_mx    <= r_mx;
            r_out_my    <= r_my;
            r_out_color <= r_color;
            r_out_last  <= cmd_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_code      = r_out_code;
    assign o_draw_x        = r_out_x;
    assign o_draw_y        = r_out_y;
    assign o_draw_width    = r_out_w;
    assign o_draw_height   = r_out_h;
    assign o_mirror_x      = r_out_mx;
    assign o_mirror_y      = r_out_my;
    assign o_palette_color = r_out_color;
    assign o_last_tile     = r_out_last;

endmodule
